@@ rtl/rttp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttp_pkg
// Shared types, character codes and the pitch table for the ringtone parser.
// ----------------------------------------------------------------------------
package rttp_pkg;

   localparam int DIV_STEPS = 20;
   localparam int DIV_CNT_W = 5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_LOW_D = 8'h64;
   localparam logic [7:0] CH_LOW_O = 8'h6F;
   localparam logic [7:0] CH_LOW_B = 8'h62;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [19:0] MS_PER_MINUTE = 20'd60000;
   localparam logic [15:0] RST_BPM       = 16'd63;
   localparam logic [19:0] RST_WHOLE     = 20'd3808;
   localparam logic [7:0]  RST_LEN       = 8'd4;
   localparam logic [3:0]  RST_OCTAVE    = 4'd6;
   localparam logic [19:0] GAP_MS        = 20'd8;

   // One classified text byte.
   typedef struct packed {
      logic [7:0] ch;
      logic       first;
      logic       is_nul;
      logic       is_dig;
      logic [3:0] dig;
      logic [3:0] lcode;
   } tok_type;

   typedef struct packed {
      logic [11:0] freq_hz;
      logic [19:0] duration_ms;
      logic [19:0] wait_ms;
      logic        is_rest;
      logic        bad_pitch;
   } note_type;

   function automatic logic [11:0] pitch_hz(input logic [5:0] idx);
      logic [11:0] f;
      case (idx)
         6'd1:  f = 12'd262;   6'd2:  f = 12'd277;   6'd3:  f = 12'd294;
         6'd4:  f = 12'd311;   6'd5:  f = 12'd330;   6'd6:  f = 12'd349;
         6'd7:  f = 12'd370;   6'd8:  f = 12'd392;   6'd9:  f = 12'd415;
         6'd10: f = 12'd440;   6'd11: f = 12'd466;   6'd12: f = 12'd494;
         6'd13: f = 12'd523;   6'd14: f = 12'd554;   6'd15: f = 12'd587;
         6'd16: f = 12'd622;   6'd17: f = 12'd659;   6'd18: f = 12'd698;
         6'd19: f = 12'd740;   6'd20: f = 12'd784;   6'd21: f = 12'd831;
         6'd22: f = 12'd880;   6'd23: f = 12'd932;   6'd24: f = 12'd988;
         6'd25: f = 12'd1047;  6'd26: f = 12'd1109;  6'd27: f = 12'd1175;
         6'd28: f = 12'd1245;  6'd29: f = 12'd1319;  6'd30: f = 12'd1397;
         6'd31: f = 12'd1480;  6'd32: f = 12'd1568;  6'd33: f = 12'd1661;
         6'd34: f = 12'd1760;  6'd35: f = 12'd1865;  6'd36: f = 12'd1976;
         6'd37: f = 12'd2093;  6'd38: f = 12'd2217;  6'd39: f = 12'd2349;
         6'd40: f = 12'd2489;  6'd41: f = 12'd2637;  6'd42: f = 12'd2794;
         6'd43: f = 12'd2960;  6'd44: f = 12'd3136;  6'd45: f = 12'd3322;
         6'd46: f = 12'd3520;  6'd47: f = 12'd3729;  6'd48: f = 12'd3951;
         default: f = 12'd0;
      endcase
      return f;
   endfunction

endpackage

@@ rtl/rttp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttp_req_if / rttp_rsp_if
// Valid/ready channels for text bytes and for note results.
// ----------------------------------------------------------------------------
interface rttp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       first;
   modport source (output valid, output ch, output first, input ready);
   modport sink   (input valid, input ch, input first, output ready);
endinterface

interface rttp_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] freq_hz;
   logic [19:0] duration_ms;
   logic [19:0] wait_ms;
   logic        is_rest;
   logic        bad_pitch;
   modport source (output valid, output freq_hz, output duration_ms, output wait_ms,
                   output is_rest, output bad_pitch, input ready);
   modport sink   (input valid, input freq_hz, input duration_ms, input wait_ms,
                   input is_rest, input bad_pitch, output ready);
endinterface

@@ rtl/ringtone_text_note_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_top
// A note result is registered at the edge where its closing byte leaves the
// queue; that byte is first written into the queue when it is accepted.
// A note's first non-digit byte or the end of the header starts the 20-bit
// restoring divider, and the parser takes no further byte until it is done.
// The front keeps accepting into a two-entry queue while the parser divides.
// Synchronous active-high reset returns the parser to the name phase.
// ----------------------------------------------------------------------------
module ringtone_text_note_parser_top import rttp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rttp_req_if.sink   req_if,
   rttp_rsp_if.source rsp_if
);

   logic    q_full, q_push, q_pop, q_ne;
   tok_type q_tok, q_head;

   rttp_front u_front (
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_tok  (q_tok)
   );

   rttp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_tok  (q_tok),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_ne),
      .head      (q_head)
   );

   rttp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_ne),
      .tok       (q_head),
      .tok_pop   (q_pop),
      .rsp_if    (rsp_if)
   );

endmodule

@@ rtl/rttp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttp_front
// Accepts text bytes and classifies them into digit, pitch letter and end mark.
// ----------------------------------------------------------------------------
module rttp_front import rttp_pkg::*; (
   rttp_req_if.sink  req_if,
   input  logic      q_full,
   output logic      q_push,
   output tok_type   q_tok
);

   logic [7:0] lc;

   assign req_if.ready = !q_full;
   assign q_push       = req_if.valid && !q_full;

   // Fold upper case onto lower case for the letter lookup.
   assign lc = req_if.ch | 8'h20;

   always_comb begin
      q_tok        = '0;
      q_tok.ch     = req_if.ch;
      q_tok.first  = req_if.first;
      q_tok.is_nul = (req_if.ch == CH_NUL);
      q_tok.is_dig = (req_if.ch >= CH_ZERO) && (req_if.ch <= CH_NINE);
      q_tok.dig    = req_if.ch[3:0];
      case (lc)
         8'h63:   q_tok.lcode = 4'd1;
         8'h64:   q_tok.lcode = 4'd3;
         8'h65:   q_tok.lcode = 4'd5;
         8'h66:   q_tok.lcode = 4'd6;
         8'h67:   q_tok.lcode = 4'd8;
         8'h61:   q_tok.lcode = 4'd10;
         8'h62:   q_tok.lcode = 4'd12;
         default: q_tok.lcode = 4'd0;
      endcase
      if (req_if.ch[7:6] != 2'b01) begin
         q_tok.lcode = 4'd0;
      end
   end

endmodule

@@ rtl/rttp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttp_queue
// Two-entry queue of classified bytes between the front and the parser.
// ----------------------------------------------------------------------------
module rttp_queue import rttp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tok_type push_tok,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output tok_type head
);

   tok_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/rttp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttp_div
// Restoring divider, 20-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rttp_div import rttp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [19:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [19:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [19:0]          q_ff, q_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          dsr_ff, dsr_in;
   logic [16:0]          trial;

   assign done     = done_ff;
   assign quotient = q_ff;
   assign trial    = {rem_ff, q_ff[19]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 16'(trial - {1'b0, dsr_ff});
            q_in   = {q_ff[18:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            q_in   = {q_ff[18:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

@@ rtl/rttp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttp_back
// Parser state machine: header fields, note fields and the result register.
// ----------------------------------------------------------------------------
module rttp_back import rttp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       tok_valid,
   input  tok_type    tok,
   output logic       tok_pop,
   rttp_rsp_if.source rsp_if
);

   localparam logic [4:0] PH_NAME    = 5'd0;
   localparam logic [4:0] PH_D_CHECK = 5'd1;
   localparam logic [4:0] PH_D_EQ    = 5'd2;
   localparam logic [4:0] PH_D_NUM   = 5'd3;
   localparam logic [4:0] PH_O_CHECK = 5'd4;
   localparam logic [4:0] PH_O_EQ    = 5'd5;
   localparam logic [4:0] PH_O_DIG   = 5'd6;
   localparam logic [4:0] PH_O_COMMA = 5'd7;
   localparam logic [4:0] PH_B_CHECK = 5'd8;
   localparam logic [4:0] PH_B_EQ    = 5'd9;
   localparam logic [4:0] PH_B_NUM   = 5'd10;
   localparam logic [4:0] PH_N_LEN   = 5'd11;
   localparam logic [4:0] PH_N_SHARP = 5'd12;
   localparam logic [4:0] PH_N_DOT   = 5'd13;
   localparam logic [4:0] PH_N_OCT   = 5'd14;
   localparam logic [4:0] PH_N_END   = 5'd15;
   localparam logic [4:0] PH_DONE    = 5'd16;

   function automatic logic [15:0] acc_digit(input logic [15:0] a, input logic [3:0] d);
      logic [19:0] v;
      v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {16'd0, d};
      return (v > 20'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   logic [4:0]  phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  dlen_ff, dlen_in;
   logic [3:0]  doct_ff, doct_in;
   logic [15:0] bpm_ff, bpm_in;
   logic [19:0] whole_ff, whole_in;
   logic [3:0]  code_ff, code_in;
   logic [3:0]  oct_ff, oct_in;
   logic [19:0] len_ff, len_in;
   logic        wait_ff, wait_in;
   logic        mode_ff, mode_in;
   logic        vld_ff, vld_in;
   note_type    out_ff, out_in;

   logic        div_go, div_start, div_done;
   logic [19:0] div_a, div_q;
   logic [15:0] div_b;

   logic [4:0]  p, cur_ph;
   logic [15:0] cur_acc, cur_bpm, d;
   logic [7:0]  cur_dlen;
   logic [3:0]  cur_doct, cur_code, cur_oct;
   logic [19:0] cur_whole, cur_len;
   logic [20:0] grown;
   logic        h, emit, do_start;
   logic [7:0]  v;
   note_type    note;

   // The divider starts only when the byte that asks for it leaves the queue.
   assign div_start = div_go && tok_pop;

   rttp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign tok_pop = tok_valid && !wait_ff && (!vld_ff || rsp_if.ready);

   assign rsp_if.valid       = vld_ff;
   assign rsp_if.freq_hz     = out_ff.freq_hz;
   assign rsp_if.duration_ms = out_ff.duration_ms;
   assign rsp_if.wait_ms     = out_ff.wait_ms;
   assign rsp_if.is_rest     = out_ff.is_rest;
   assign rsp_if.bad_pitch   = out_ff.bad_pitch;

   // Result fields from the note held before this byte changes anything.
   always_comb begin
      v = 8'(cur_code) + {1'b0, cur_oct, 3'b000} + {2'b00, cur_oct, 2'b00};
      note             = '0;
      note.duration_ms = cur_len;
      note.wait_ms     = (cur_len > GAP_MS) ? (cur_len - GAP_MS) : 20'd0;
      note.is_rest     = 1'b1;
      if (cur_code != 4'd0) begin
         if (v >= 8'd49 && v <= 8'd96) begin
            note.freq_hz = pitch_hz(6'(v - 8'd48));
            note.is_rest = 1'b0;
         end else begin
            note.bad_pitch = 1'b1;
         end
      end
   end

   always_comb begin
      if (tok.first) begin
         cur_ph = PH_NAME;     cur_acc = '0;        cur_dlen = RST_LEN;
         cur_doct = RST_OCTAVE; cur_bpm = RST_BPM;  cur_whole = RST_WHOLE;
         cur_code = '0;        cur_oct = RST_OCTAVE; cur_len = '0;
      end else begin
         cur_ph = phase_ff;    cur_acc = acc_ff;    cur_dlen = dlen_ff;
         cur_doct = doct_ff;   cur_bpm = bpm_ff;    cur_whole = whole_ff;
         cur_code = code_ff;   cur_oct = oct_ff;    cur_len = len_ff;
      end

      phase_in = cur_ph;  acc_in = cur_acc;     dlen_in = cur_dlen;
      doct_in = cur_doct; bpm_in = cur_bpm;     whole_in = cur_whole;
      code_in = cur_code; oct_in = cur_oct;     len_in = cur_len;
      p = cur_ph;
      h = 1'b0;
      emit = 1'b0;
      do_start = 1'b0;
      div_go = 1'b0;
      div_a = MS_PER_MINUTE;
      div_b = 16'd1;
      d = 16'd1;
      grown = '0;
      mode_in = mode_ff;

      if (p == PH_DONE) begin
         h = 1'b1;
      end
      if (!h && tok.is_nul) begin
         phase_in = PH_DONE;
         emit = (p >= PH_N_SHARP) && (p <= PH_N_END);
         h = 1'b1;
      end
      if (!h && p == PH_NAME) begin
         if (tok.ch == CH_COLON) begin
            phase_in = PH_D_CHECK;
         end
         h = 1'b1;
      end
      if (!h && p == PH_D_CHECK) begin
         if (tok.ch == CH_LOW_D) begin
            phase_in = PH_D_EQ;
            h = 1'b1;
         end else begin
            p = PH_O_CHECK;
         end
      end
      if (!h && p == PH_D_EQ) begin
         acc_in = '0;
         phase_in = PH_D_NUM;
         h = 1'b1;
      end
      if (!h && p == PH_D_NUM) begin
         if (tok.is_dig) begin
            acc_in = acc_digit(cur_acc, tok.dig);
         end else begin
            if (cur_acc != 16'd0) begin
               dlen_in = (cur_acc > 16'd255) ? 8'd255 : cur_acc[7:0];
            end
            phase_in = PH_O_CHECK;
         end
         h = 1'b1;
      end
      if (!h && p == PH_O_CHECK) begin
         if (tok.ch == CH_LOW_O) begin
            phase_in = PH_O_EQ;
            h = 1'b1;
         end else begin
            p = PH_B_CHECK;
         end
      end
      if (!h && p == PH_O_EQ) begin
         phase_in = PH_O_DIG;
         h = 1'b1;
      end
      if (!h && p == PH_O_DIG) begin
         if (tok.ch >= CH_THREE && tok.ch <= CH_SEVEN) begin
            doct_in = tok.dig;
         end
         phase_in = PH_O_COMMA;
         h = 1'b1;
      end
      if (!h && p == PH_O_COMMA) begin
         phase_in = PH_B_CHECK;
         h = 1'b1;
      end
      if (!h && p == PH_B_CHECK) begin
         if (tok.ch == CH_LOW_B) begin
            phase_in = PH_B_EQ;
         end else begin
            div_go = 1'b1;
            mode_in = 1'b0;
            div_b = (cur_bpm == 16'd0) ? 16'd1 : cur_bpm;
            acc_in = '0;
            phase_in = PH_N_LEN;
         end
         h = 1'b1;
      end
      if (!h && p == PH_B_EQ) begin
         acc_in = '0;
         phase_in = PH_B_NUM;
         h = 1'b1;
      end
      if (!h && p == PH_B_NUM) begin
         if (tok.is_dig) begin
            acc_in = acc_digit(cur_acc, tok.dig);
         end else begin
            bpm_in = (cur_acc == 16'd0) ? 16'd1 : cur_acc;
            div_go = 1'b1;
            mode_in = 1'b0;
            div_b = bpm_in;
            acc_in = '0;
            phase_in = PH_N_LEN;
         end
         h = 1'b1;
      end
      if (!h && p == PH_N_LEN) begin
         do_start = 1'b1;
         h = 1'b1;
      end
      if (!h && p == PH_N_SHARP) begin
         if (tok.ch == CH_SHARP) begin
            code_in = cur_code + 4'd1;
            phase_in = PH_N_DOT;
            h = 1'b1;
         end else begin
            p = PH_N_DOT;
         end
      end
      if (!h && p == PH_N_DOT) begin
         if (tok.ch == CH_DOT || tok.ch == CH_SEMI || tok.ch == CH_AMP) begin
            if (tok.ch == CH_DOT) begin
               grown = {1'b0, cur_len} + {2'b00, cur_len[19:1]};
            end else if (tok.ch == CH_SEMI) begin
               grown = {1'b0, cur_len} + {1'b0, cur_len};
            end else begin
               grown = {1'b0, cur_len} + {2'b00, cur_len[19:1]} + {1'b0, cur_len[19:1], 1'b0};
            end
            len_in = grown[19:0];
            phase_in = PH_N_OCT;
            h = 1'b1;
         end else begin
            p = PH_N_OCT;
         end
      end
      if (!h && p == PH_N_OCT) begin
         if (tok.is_dig) begin
            oct_in = tok.dig;
            phase_in = PH_N_END;
            h = 1'b1;
         end
      end
      if (!h) begin
         // Note ends: emit it, and a byte other than a comma opens the next note.
         emit = 1'b1;
         acc_in = '0;
         phase_in = PH_N_LEN;
         do_start = (tok.ch != CH_COMMA);
      end

      if (do_start) begin
         if (tok.is_dig) begin
            acc_in = acc_digit(acc_in, tok.dig);
         end else begin
            code_in = tok.lcode;
            d = (acc_in != 16'd0) ? acc_in : {8'd0, cur_dlen};
            if (d == 16'd0) begin
               d = 16'd1;
            end
            div_go = 1'b1;
            mode_in = 1'b1;
            div_a = cur_whole;
            div_b = d;
            oct_in = cur_doct;
            phase_in = PH_N_SHARP;
         end
      end
   end

   always_comb begin
      wait_in = wait_ff;
      vld_in  = vld_ff && !rsp_if.ready;
      out_in  = out_ff;
      if (div_done) begin
         wait_in = 1'b0;
      end
      if (tok_pop) begin
         if (div_go) begin
            wait_in = 1'b1;
         end
         if (emit) begin
            vld_in = 1'b1;
            out_in = note;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NAME;
         acc_ff   <= '0;
         dlen_ff  <= RST_LEN;
         doct_ff  <= RST_OCTAVE;
         bpm_ff   <= RST_BPM;
         whole_ff <= RST_WHOLE;
         code_ff  <= '0;
         oct_ff   <= RST_OCTAVE;
         len_ff   <= '0;
         mode_ff  <= 1'b0;
         wait_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         wait_ff <= wait_in;
         vld_ff  <= vld_in;
         if (tok_pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            dlen_ff  <= dlen_in;
            doct_ff  <= doct_in;
            bpm_ff   <= bpm_in;
            whole_ff <= whole_in;
            code_ff  <= code_in;
            oct_ff   <= oct_in;
            len_ff   <= len_in;
            mode_ff  <= mode_in;
         end else if (div_done) begin
            if (mode_ff) begin
               len_ff <= div_q;
            end else begin
               whole_ff <= {div_q[17:0], 2'b00};
            end
         end
      end
   end

endmodule
